FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the decoder core RTL.
// No dependencies; SYNTH removes every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hw/rtl/b64d_pkg.sv
// Types, constants and the character map of the base64url decoder.
// No dependencies.
`timescale 1ns / 1ps

package b64d_pkg;

  localparam int MAX_BYTES = 255;
  localparam logic [7:0] EXPECTED_RESET = 8'd32;
  localparam logic [8:0] TOTAL_SAT = 9'h1FF;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEN  = 2'd1,
    ST_BAD_CHAR = 2'd2,
    ST_TRAIL    = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  // bit 6 set: not a base64url character (value field then zero)
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'h40;
    if (c >= 8'd65 && c <= 8'd90) begin
      r = {1'b0, 6'(c - 8'd65)};
    end else if (c >= 8'd97 && c <= 8'd122) begin
      r = {1'b0, 6'(c - 8'd97 + 8'd26)};
    end else if (c >= 8'd48 && c <= 8'd57) begin
      r = {1'b0, 6'(c - 8'd48 + 8'd52)};
    end else if (c == 8'd45) begin
      r = {1'b0, 6'd62};
    end else if (c == 8'd95) begin
      r = {1'b0, 6'd63};
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/b64d_in_reg.sv
// Input register stage of the base64url decoder.
// Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,  // char_code
  input  logic               s_tlast,  // last_char
  input  logic               take,
  output b64d_pkg::stage_t   stage
);

  logic                held;
  b64d_pkg::item_t     item;

  assign s_tready = !rst && (!held || take);

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_tready) begin
      held <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.char_code <= s_tdata;
      item.last_char <= s_tlast;
    end
  end

  assign stage.valid = held;
  assign stage.item  = item;

endmodule

FILE: hw/rtl/b64d_core.sv
// Decode state, status check and result register of the base64url decoder.
// Depends on b64d_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b64d_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  b64d_pkg::stage_t   stage,
  output logic               take,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         m_tdata,  // out_byte
  output logic [2:0]         m_tuser,  // out_valid, status[1:0]
  output logic               m_tlast   // done_res
);

  logic [7:0]  expected_bytes;
  logic [6:0]  bit_buffer;
  logic [2:0]  bit_count;
  logic [8:0]  byte_total;
  logic [1:0]  length_phase;
  logic        bad_char_seen;

  logic        ov;
  logic [7:0]  o_byte;
  logic        o_valid;
  logic        o_done;
  b64d_pkg::status_t o_status;

  logic [6:0]  sext;
  logic [12:0] acc;
  logic [3:0]  cnt_sum;
  logic        emit;
  logic [2:0]  bit_count_next;
  logic [7:0]  shifted;
  logic [6:0]  mask;
  logic [6:0]  bit_buffer_next;
  logic [8:0]  byte_total_next;
  logic [1:0]  length_phase_next;
  logic        bad_char_seen_next;
  logic        byte_ok;
  logic        state_clear;
  b64d_pkg::status_t status_next;

  assign take = stage.valid && (!ov || m_tready);

  always_comb begin
    sext               = b64d_pkg::sextet_of(stage.item.char_code);
    acc                = {bit_buffer, sext[5:0]};
    cnt_sum            = {1'b0, bit_count} + 4'd6;
    emit               = cnt_sum[3];
    bit_count_next     = cnt_sum[2:0];
    shifted            = 8'(acc >> bit_count_next);
    mask               = (7'd1 << bit_count_next) - 7'd1;
    bit_buffer_next    = emit ? acc[6:0] & mask : acc[6:0];
    byte_ok            = emit && (byte_total < {1'b0, expected_bytes})
                         && (byte_total < 9'(b64d_pkg::MAX_BYTES));
    byte_total_next    = (emit && byte_total != b64d_pkg::TOTAL_SAT)
                         ? byte_total + 9'd1 : byte_total;
    length_phase_next  = length_phase + 2'd1;
    bad_char_seen_next = bad_char_seen || sext[6];
  end

  always_comb begin
    if (length_phase_next == 2'd1 || byte_total_next != {1'b0, expected_bytes}) begin
      status_next = b64d_pkg::ST_BAD_LEN;
    end else if (bad_char_seen_next) begin
      status_next = b64d_pkg::ST_BAD_CHAR;
    end else if (bit_buffer_next != 7'd0) begin
      status_next = b64d_pkg::ST_TRAIL;
    end else begin
      status_next = b64d_pkg::ST_OK;
    end
  end

  assign state_clear = bit_buffer == 7'd0 && bit_count == 3'd0 && byte_total == 9'd0
                       && length_phase == 2'd0 && !bad_char_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_bytes <= b64d_pkg::EXPECTED_RESET;
    end else if (cfg_we) begin
      expected_bytes <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buffer    <= 7'd0;
      bit_count     <= 3'd0;
      byte_total    <= 9'd0;
      length_phase  <= 2'd0;
      bad_char_seen <= 1'b0;
    end else if (take) begin
      if (stage.item.last_char) begin
        bit_buffer    <= 7'd0;
        bit_count     <= 3'd0;
        byte_total    <= 9'd0;
        length_phase  <= 2'd0;
        bad_char_seen <= 1'b0;
      end else begin
        bit_buffer    <= bit_buffer_next;
        bit_count     <= bit_count_next;
        byte_total    <= byte_total_next;
        length_phase  <= length_phase_next;
        bad_char_seen <= bad_char_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (take) begin
      ov <= 1'b1;
    end else if (m_tready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      o_byte   <= byte_ok ? shifted : 8'd0;
      o_valid  <= byte_ok;
      o_done   <= stage.item.last_char;
      o_status <= stage.item.last_char ? status_next : b64d_pkg::ST_OK;
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = o_byte;
  assign m_tuser  = {o_status, o_valid};
  assign m_tlast  = o_done;

  `ASSERT_ALWAYS(a_status_only_done, clk, rst, !ov || o_done || o_status == b64d_pkg::ST_OK)
  `ASSERT_ALWAYS(a_count_even, clk, rst, bit_count[0] == 1'b0)
  `ASSERT_NEXT(a_clear_after_last, clk, rst, take && stage.item.last_char, state_clear)

endmodule

FILE: hw/rtl/base64url_strict_decoder_top.sv
// Top level of the strict unpadded base64url decoder.
// Depends on b64d_pkg, b64d_in_reg and b64d_core.
//
// Usage:
//   Slave stream s_*: one ASCII character per transfer in s_tdata, s_tlast
//   set on the final character of a string.
//   Master stream m_*: exactly one result per character. m_tdata is the
//   decoded byte, m_tuser[0] flags it as a real byte, m_tuser[2:1] is the
//   status, m_tlast marks the result of the final character.
//   Status on the final result: 0 ok, 1 bad length, 2 invalid character,
//   3 nonzero trailing bits.
//   cfg_we/cfg_wdata write the expected byte count; write only while idle.
//   An accepted character passes the input register, then the result
//   register.
//   Throughput: one character per cycle while m_tready is high; the
//   per-character map and shift sit between the two registers.
//   Reset clears the decode state and sets the expected count to 32.
//   When m_tready is low a valid result register holds; the input register
//   takes one more character only if it is empty, then s_tready drops.
`timescale 1ns / 1ps

module base64url_strict_decoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,  // expected_bytes
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,    // char_code
  input  logic       s_tlast,    // last_char
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,    // out_byte
  output logic [2:0] m_tuser,    // out_valid, status[1:0]
  output logic       m_tlast     // done_res
);

  b64d_pkg::stage_t stage;
  logic             take;

  b64d_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .take     (take),
    .stage    (stage)
  );

  b64d_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stage     (stage),
    .take      (take),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

FILE: bench/tb.sv
// Self-checking bench for base64url_strict_decoder_top: directed strings, then random ones.
// A local decoder model predicts each result; depends on b64d_pkg and the RTL top.
`timescale 1ns / 1ps

module tb;

  typedef logic [7:0] octet_q_t[$];

  typedef struct packed {
    logic [7:0]        data;
    logic              valid;
    logic              done;
    b64d_pkg::status_t status;
  } dec_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'd0;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [2:0] m_tuser;
  logic       m_tlast;

  // decoder model state
  logic [7:0] p_expected = b64d_pkg::EXPECTED_RESET;
  logic [6:0] p_buf = '0;
  logic [2:0] p_cnt = '0;
  logic [8:0] p_total = '0;
  logic [1:0] p_phase = '0;
  logic       p_bad = 1'b0;

  dec_result_t decoded_q[$];
  int          n_fail = 0;
  int          n_chars = 0;
  int          tx_idle_pct = 7;
  int          rx_idle_pct = 7;
  logic        rx_hold = 1'b0;

  base64url_strict_decoder_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // char_code
    .s_tlast   (s_tlast),    // last_char
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // out_byte
    .m_tuser   (m_tuser),    // out_valid, status[1:0]
    .m_tlast   (m_tlast)     // done_res
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("base64url_strict_decoder_top regression: fail");
    $finish;
  end

  // bit 6 flags a character outside the alphabet
  function automatic logic [6:0] char_value(input logic [7:0] c);
    logic [6:0] v;
    v = 7'h40;
    if (c >= "A" && c <= "Z") v = {1'b0, 6'(c - "A")};
    else if (c >= "a" && c <= "z") v = {1'b0, 6'(c - "a" + 26)};
    else if (c >= "0" && c <= "9") v = {1'b0, 6'(c - "0" + 52)};
    else if (c == "-") v = 7'd62;
    else if (c == "_") v = 7'd63;
    return v;
  endfunction

  function automatic logic [7:0] value_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 26) c = 8'("A" + v);
    else if (v < 52) c = 8'("a" + v - 26);
    else if (v < 62) c = 8'("0" + v - 52);
    else if (v == 62) c = "-";
    else c = "_";
    return c;
  endfunction

  function automatic octet_q_t encode_bytes(input octet_q_t data);
    octet_q_t txt;
    logic [15:0] acc;
    int nbits;
    acc = '0;
    nbits = 0;
    for (int i = 0; i < data.size(); i++) begin
      acc = {acc[7:0], data[i]};
      nbits += 8;
      while (nbits >= 6) begin
        txt.push_back(value_char(6'(acc >> (nbits - 6))));
        nbits -= 6;
      end
    end
    if (nbits > 0) txt.push_back(value_char(6'(acc << (6 - nbits))));
    return txt;
  endfunction

  function automatic logic [7:0] random_invalid();
    logic [7:0] c;
    logic [6:0] v;
    do begin
      c = 8'($urandom_range(255));
      v = char_value(c);
    end while (!v[6]);
    return c;
  endfunction

  function automatic dec_result_t decode_char(input logic [7:0] c, input logic last);
    dec_result_t r;
    logic [6:0]  sx;
    logic [12:0] acc;
    logic [3:0]  cnt;
    r = '{data: 8'd0, valid: 1'b0, done: 1'b0, status: b64d_pkg::ST_OK};
    sx = char_value(c);
    if (sx[6]) p_bad = 1'b1;
    acc = {p_buf, sx[5:0]};
    cnt = {1'b0, p_cnt} + 4'd6;
    if (cnt >= 4'd8) begin
      cnt = cnt - 4'd8;
      if (p_total < {1'b0, p_expected} && p_total < b64d_pkg::MAX_BYTES) begin
        r.data = 8'(acc >> cnt);
        r.valid = 1'b1;
      end
      if (p_total != b64d_pkg::TOTAL_SAT) p_total = p_total + 9'd1;
      acc = acc & ((13'd1 << cnt) - 13'd1);
    end
    p_buf = acc[6:0];
    p_cnt = cnt[2:0];
    p_phase = p_phase + 2'd1;
    if (last) begin
      r.done = 1'b1;
      if (p_phase == 2'd1 || p_total != {1'b0, p_expected}) r.status = b64d_pkg::ST_BAD_LEN;
      else if (p_bad) r.status = b64d_pkg::ST_BAD_CHAR;
      else if (p_buf != '0) r.status = b64d_pkg::ST_TRAIL;
      p_buf = '0;
      p_cnt = '0;
      p_total = '0;
      p_phase = '0;
      p_bad = 1'b0;
    end
    return r;
  endfunction

  task automatic send_char(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    decoded_q.push_back(decode_char(c, last));
    n_chars++;
  endtask

  task automatic send_text(input octet_q_t txt);
    for (int i = 0; i < txt.size(); i++) send_char(txt[i], i == txt.size() - 1);
  endtask

  task automatic send_str(input string s);
    octet_q_t txt;
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    send_text(txt);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_expected(input logic [7:0] count);
    drain();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we <= 1'b0;
    p_expected = count;
  endtask

  task automatic send_random_string();
    octet_q_t   data;
    octet_q_t   txt;
    int         kind;
    int         pos;
    logic [6:0] v;
    for (int i = 0; i < p_expected; i++) data.push_back(8'($urandom_range(255)));
    txt = encode_bytes(data);
    kind = $urandom_range(99);
    if (kind >= 92 || txt.size() == 0) begin
      txt.delete();
      repeat ($urandom_range(1, 12)) txt.push_back(8'($urandom_range(255)));
    end else if (kind >= 80) begin
      pos = $urandom_range(txt.size() - 1);
      txt[pos] = random_invalid();
    end else if (kind >= 72) begin
      if ($urandom_range(1) == 1 && txt.size() > 1) void'(txt.pop_back());
      else txt.push_back(value_char(6'($urandom_range(63))));
    end else if (kind >= 64 && (p_expected % 3) != 0) begin
      // flip a leftover bit in the final character
      v = char_value(txt[txt.size() - 1]);
      txt[txt.size() - 1] = value_char(v[5:0] ^ 6'd1);
    end
    send_text(txt);
  endtask

  task automatic random_strings(input int n_items);
    int start;
    int r;
    start = n_chars;
    while (n_chars - start < n_items) begin
      if ($urandom_range(99) < 15) begin
        r = $urandom_range(99);
        if (r < 10) set_expected(8'd0);
        else if (r < 25) set_expected(8'($urandom_range(13, 48)));
        else set_expected(8'($urandom_range(1, 12)));
      end
      send_random_string();
    end
  endtask

  task automatic test_single_char();
    set_expected(8'd0);
    send_str("A");
  endtask

  task automatic test_status_codes();
    octet_q_t txt;
    set_expected(8'd1);
    send_str("_w");
    send_str("AA");
    send_str("_x");
    send_str("A*");
    txt = '{8'hFF, 8'h00};
    send_text(txt);
    send_str("*");
  endtask

  task automatic test_count_limits();
    set_expected(8'd2);
    send_str("-_8");
    set_expected(8'd1);
    send_str("AAAA");
    set_expected(8'd0);
    send_str("AA");
    set_expected(8'd255);
    send_str("zz");
  endtask

  task automatic test_backpressure();
    set_expected(8'd15);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (50) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    send_random_string();
    drain();
  endtask

  task automatic test_longest_string();
    set_expected(8'd255);
    send_random_string();
  endtask

  task automatic test_no_idle();
    set_expected(8'd9);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_strings(150);
    tx_idle_pct = 7;
    rx_idle_pct = 7;
  endtask

  task automatic test_random();
    set_expected(b64d_pkg::EXPECTED_RESET);
    random_strings(300);
  endtask

  always @(posedge clk) begin : check_results
    dec_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected transfer: expected none, actual data %h user %b last %b",
                 $time, m_tdata, m_tuser, m_tlast);
        n_fail++;
      end else begin
        want = decoded_q.pop_front();
        if (m_tdata !== want.data) begin
          $display("%0t: out_byte expected %h actual %h", $time, want.data, m_tdata);
          n_fail++;
        end
        if (m_tuser[0] !== want.valid) begin
          $display("%0t: out_valid expected %b actual %b", $time, want.valid, m_tuser[0]);
          n_fail++;
        end
        if (m_tlast !== want.done) begin
          $display("%0t: done_res expected %b actual %b", $time, want.done, m_tlast);
          n_fail++;
        end
        if (m_tuser[2:1] !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser[2:1]);
          n_fail++;
        end
      end
    end
    m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_char();
    test_status_codes();
    test_count_limits();
    test_backpressure();
    test_longest_string();
    test_no_idle();
    test_random();
    drain();
    repeat (4) @(posedge clk);
    if (n_fail == 0 && decoded_q.size() == 0) begin
      $display("base64url_strict_decoder_top regression: pass");
    end else begin
      $display("base64url_strict_decoder_top regression: fail");
    end
    $finish;
  end

endmodule
